/* design/pwc_pkg.sv */
// pwc_pkg: shared codes and types for the power window controller.
// No dependencies; imported by power_window_controller.
package pwc_pkg;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  localparam logic [CfgIdxW-1:0] REG_HOLD_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_TICKS  = 2'd1;

  localparam logic [CfgW-1:0] HOLD_THRESHOLD_RST = 16'd300;
  localparam logic [CfgW-1:0] REVERSE_TICKS_RST  = 16'd1000;

  // bit positions within the sampled level vector
  localparam int LVL_LOCK     = 4;
  localparam int LVL_TOP      = 5;
  localparam int LVL_BOTTOM   = 6;
  localparam int LVL_OBSTACLE = 7;

  localparam int NUM_BUTTONS = 4;

endpackage

/* design/power_window_controller.sv */
// power_window_controller: tick-driven window motor control with auto/manual
// modes, passenger lock, latched limits and obstacle reversal.
// Depends on pwc_pkg.

// Each item is one tick of sampled switch levels and yields exactly one result
// item. An item is processed combinationally and its result appears in the
// output register on the next cycle; one item per cycle is sustained, the
// output register taking a new result whenever the downstream side is not
// stalling. Configuration writes are always ready and should be issued only
// while no item is in flight.
module power_window_controller #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         driver_up_button_i,
  input  logic                         driver_down_button_i,
  input  logic                         passenger_up_button_i,
  input  logic                         passenger_down_button_i,
  input  logic                         lock_button_i,
  input  logic                         top_limit_switch_i,
  input  logic                         bottom_limit_switch_i,
  input  logic                         obstacle_sensor_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pwc_pkg::dir_t                motor_direction_o,
  output logic                         reversing_o,
  output logic                         lock_active_o,
  output logic                         at_top_o,
  output logic                         at_bottom_o,
  output logic                         motion_owner_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwc_pkg::CfgW-1:0]     cfg_data_i
);
  import pwc_pkg::*;

  localparam int CmpW = (COUNTER_BITS > CfgW) ? COUNTER_BITS : CfgW;
  localparam logic [COUNTER_BITS-1:0] CntMax = {COUNTER_BITS{1'b1}};

  logic [CfgW-1:0]         hold_thr_q, rev_ticks_q;
  logic [7:0]              prev_q, levels;
  logic [COUNTER_BITS-1:0] hold_cnt_q [NUM_BUTTONS];
  logic [COUNTER_BITS-1:0] hold_cnt_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  run_q, run_d;
  dir_t                    dir_q, dir_d;
  logic                    owner_q, owner_d;
  logic                    lock_q, lock_d;
  logic                    top_q, top_d, bot_q, bot_d;
  logic [COUNTER_BITS-1:0] rcnt_q, rcnt_d;
  logic                    rev_q, rev_d;

  logic                    out_valid_q;
  dir_t                    out_dir_q;
  logic                    out_rev_q, out_lock_q, out_top_q, out_bot_q, out_owner_q;

  logic                    accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign levels = {obstacle_sensor_i, bottom_limit_switch_i, top_limit_switch_i,
                   lock_button_i, passenger_down_button_i, passenger_up_button_i,
                   driver_down_button_i, driver_up_button_i};

  always_comb begin
    logic [7:0]              rise, fall;
    logic [CmpW-1:0]         clip_w;
    logic [COUNTER_BITS-1:0] n;
    logic                    pick_v;
    logic [1:0]              pick;

    rise = levels & ~prev_q;
    fall = prev_q & ~levels;

    lock_d  = lock_q ^ rise[LVL_LOCK];
    run_d   = run_q;
    dir_d   = dir_q;
    owner_d = owner_q;
    top_d   = top_q;
    bot_d   = bot_q;
    rcnt_d  = rcnt_q;
    rev_d   = rev_q;

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hold_cnt_d[i] = (run_q[i] && hold_cnt_q[i] != CntMax) ?
                      hold_cnt_q[i] + 1'b1 : hold_cnt_q[i];
    end

    if (rev_d) begin
      if (rcnt_d != '0) rcnt_d = rcnt_d - 1'b1;
      if (rcnt_d == '0) begin
        dir_d = DIR_STOP;
        rev_d = 1'b0;
      end
    end

    clip_w = (CmpW'(rev_ticks_q) > CmpW'(CntMax)) ? CmpW'(CntMax) : CmpW'(rev_ticks_q);
    n      = clip_w[COUNTER_BITS-1:0];

    if (dir_d == DIR_DOWN && levels[LVL_BOTTOM]) begin
      bot_d  = 1'b1;
      dir_d  = DIR_STOP;
      rev_d  = 1'b0;
      rcnt_d = '0;
    end else if (dir_d == DIR_UP && levels[LVL_TOP]) begin
      top_d  = 1'b1;
      dir_d  = DIR_STOP;
      rev_d  = 1'b0;
      rcnt_d = '0;
    end else if (dir_d == DIR_UP && rise[LVL_OBSTACLE]) begin
      run_d   = '0;
      owner_d = 1'b0;
      if (n == '0) begin
        dir_d  = DIR_STOP;
        rev_d  = 1'b0;
        rcnt_d = '0;
      end else begin
        dir_d  = DIR_DOWN;
        rev_d  = 1'b1;
        rcnt_d = n;
      end
    end

    // releases: manual mode stops the motor when the owner lets go
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (fall[i] && run_d[i]) begin
        if (!rev_d && CmpW'(hold_cnt_d[i]) > CmpW'(hold_thr_q) &&
            owner_d == 1'(i >> 1) && dir_d != DIR_STOP) begin
          dir_d  = DIR_STOP;
          rcnt_d = '0;
        end
        run_d[i] = 1'b0;
      end
    end

    pick_v = 1'b0;
    pick   = 2'd0;
    if (!rev_d) begin
      if (rise[0] && !top_d) begin
        pick_v = 1'b1; pick = 2'd0;
      end else if (rise[1] && !bot_d) begin
        pick_v = 1'b1; pick = 2'd1;
      end else if (rise[2] && !top_d && !lock_d) begin
        pick_v = 1'b1; pick = 2'd2;
      end else if (rise[3] && !bot_d && !lock_d) begin
        pick_v = 1'b1; pick = 2'd3;
      end
    end
    if (pick_v) begin
      owner_d = pick[1];
      if (!pick[0]) begin
        dir_d = DIR_UP;
        bot_d = 1'b0;
      end else begin
        dir_d = DIR_DOWN;
        top_d = 1'b0;
      end
      hold_cnt_d[pick] = '0;
      run_d[pick]      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_thr_q  <= HOLD_THRESHOLD_RST;
      rev_ticks_q <= REVERSE_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HOLD_THRESHOLD: hold_thr_q  <= cfg_data_i;
        REG_REVERSE_TICKS:  rev_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) hold_cnt_q[i] <= '0;
      run_q   <= '0;
      dir_q   <= DIR_STOP;
      owner_q <= 1'b0;
      lock_q  <= 1'b0;
      top_q   <= 1'b0;
      bot_q   <= 1'b0;
      rcnt_q  <= '0;
      rev_q   <= 1'b0;
    end else if (accept) begin
      prev_q  <= levels;
      for (int i = 0; i < NUM_BUTTONS; i++) hold_cnt_q[i] <= hold_cnt_d[i];
      run_q   <= run_d;
      dir_q   <= dir_d;
      owner_q <= owner_d;
      lock_q  <= lock_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      rcnt_q  <= rcnt_d;
      rev_q   <= rev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_dir_q   <= dir_d;
      out_rev_q   <= rev_d;
      out_lock_q  <= lock_d;
      out_top_q   <= top_d;
      out_bot_q   <= bot_d;
      out_owner_q <= owner_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_direction_o = out_dir_q;
  assign reversing_o       = out_rev_q;
  assign lock_active_o     = out_lock_q;
  assign at_top_o          = out_top_q;
  assign at_bottom_o       = out_bot_q;
  assign motion_owner_o    = out_owner_q;

`ifndef ASSERT_OFF
  a_rev_moves_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_q |-> (dir_q == DIR_DOWN && rcnt_q != '0))
    else $error("reversal without downward drive or with empty count");

  a_limits_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(top_q && bot_q))
    else $error("both limit flags latched");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_o && motor_direction_o == dir_q && reversing_o == rev_q))
    else $error("result register out of step with state");
`endif

endmodule

/* dv/window_motor_checker.sv */
// window_motor_checker: watches the tick, result and register channels of
// power_window_controller, predicts each result and compares it field by field.
// Depends on pwc_pkg.
`timescale 1ns / 100ps

module window_motor_checker #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   levels_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  pwc_pkg::dir_t                motor_direction_i,
  input  logic                         reversing_i,
  input  logic                         lock_active_i,
  input  logic                         at_top_i,
  input  logic                         at_bottom_i,
  input  logic                         motion_owner_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [pwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwc_pkg::CfgW-1:0]     cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           compared_o
);
  import pwc_pkg::*;

  typedef enum int {BTN_DRV_UP, BTN_DRV_DOWN, BTN_PAS_UP, BTN_PAS_DOWN} button_e;

  typedef struct packed {
    dir_t motor;
    logic reversing;
    logic lock;
    logic top;
    logic bottom;
    logic owner;
  } window_out_t;

  localparam logic SIDE_DRIVER    = 1'b0;
  localparam logic SIDE_PASSENGER = 1'b1;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam int PRINT_CAP = 40;

  logic [CfgW-1:0]         hold_thr_q;
  logic [CfgW-1:0]         rev_ticks_q;
  logic [7:0]              prev_levels;
  logic [COUNTER_BITS-1:0] hold_cnt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  timing_q;
  dir_t                    dir_q;
  logic                    owner_q;
  logic                    lock_q;
  logic                    at_top_q;
  logic                    at_bottom_q;
  logic [COUNTER_BITS-1:0] rev_cnt;
  logic                    reversing_q;

  window_out_t motor_states_due [$];
  window_out_t due;
  window_out_t seen;

  function automatic void halt_motor();
    dir_q       = DIR_STOP;
    reversing_q = 1'b0;
    rev_cnt     = '0;
  endfunction

  task automatic advance_window_tick(input logic [7:0] lv, output window_out_t res);
    logic [7:0] rise;
    logic [7:0] fall;
    logic [COUNTER_BITS-1:0] rev_load;
    logic side;
    int pick;
    rise        = lv & ~prev_levels;
    fall        = prev_levels & ~lv;
    prev_levels = lv;
    if (rise[LVL_LOCK]) lock_q = ~lock_q;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (timing_q[b] && hold_cnt[b] != CNT_MAX) hold_cnt[b] = hold_cnt[b] + 1'b1;
    end
    if (reversing_q) begin
      if (rev_cnt != '0) rev_cnt = rev_cnt - 1'b1;
      if (rev_cnt == '0) halt_motor();
    end
    if (dir_q == DIR_DOWN && lv[LVL_BOTTOM]) begin
      at_bottom_q = 1'b1;
      halt_motor();
    end else if (dir_q == DIR_UP && lv[LVL_TOP]) begin
      at_top_q = 1'b1;
      halt_motor();
    end else if (dir_q == DIR_UP && rise[LVL_OBSTACLE]) begin
      rev_load = (rev_ticks_q > CNT_MAX) ? CNT_MAX : COUNTER_BITS'(rev_ticks_q);
      timing_q = '0;
      owner_q  = SIDE_DRIVER;
      if (rev_load == '0) begin
        halt_motor();
      end else begin
        dir_q       = DIR_DOWN;
        reversing_q = 1'b1;
        rev_cnt     = rev_load;
      end
    end
    // releases: manual stop only for the side that owns the motion
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (fall[b] && timing_q[b]) begin
        side = (b == BTN_PAS_UP || b == BTN_PAS_DOWN) ? SIDE_PASSENGER : SIDE_DRIVER;
        if (!reversing_q && hold_cnt[b] > hold_thr_q && owner_q == side &&
            dir_q != DIR_STOP) halt_motor();
        timing_q[b] = 1'b0;
      end
    end
    if (!reversing_q) begin
      pick = -1;
      if (rise[BTN_DRV_UP] && !at_top_q) pick = BTN_DRV_UP;
      else if (rise[BTN_DRV_DOWN] && !at_bottom_q) pick = BTN_DRV_DOWN;
      else if (rise[BTN_PAS_UP] && !at_top_q && !lock_q) pick = BTN_PAS_UP;
      else if (rise[BTN_PAS_DOWN] && !at_bottom_q && !lock_q) pick = BTN_PAS_DOWN;
      if (pick >= 0) begin
        dir_q   = (pick == BTN_DRV_UP || pick == BTN_PAS_UP) ? DIR_UP : DIR_DOWN;
        owner_q = (pick >= BTN_PAS_UP) ? SIDE_PASSENGER : SIDE_DRIVER;
        if (dir_q == DIR_UP) at_bottom_q = 1'b0;
        else at_top_q = 1'b0;
        hold_cnt[pick] = '0;
        timing_q[pick] = 1'b1;
      end
    end
    res = {dir_q, reversing_q, lock_q, at_top_q, at_bottom_q, owner_q};
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches_o < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [1:0] got,
                             input logic [1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s = %0d, predicted %0d",
                              compared_o, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_thr_q   = HOLD_THRESHOLD_RST;
      rev_ticks_q  = REVERSE_TICKS_RST;
      prev_levels  = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) hold_cnt[b] = '0;
      timing_q     = '0;
      owner_q      = SIDE_DRIVER;
      lock_q       = 1'b0;
      at_top_q     = 1'b0;
      at_bottom_q  = 1'b0;
      halt_motor();
      motor_states_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
      compared_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_HOLD_THRESHOLD) hold_thr_q = cfg_data_i;
        else if (cfg_index_i == REG_REVERSE_TICKS) rev_ticks_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        advance_window_tick(levels_i, due);
        motor_states_due.push_back(due);
      end
      if (out_valid_i && !out_stall_i) begin
        seen = {motor_direction_i, reversing_i, lock_active_i, at_top_i, at_bottom_i,
                motion_owner_i};
        if (motor_states_due.size() == 0) begin
          flag_mismatch("result with no tick outstanding");
        end else begin
          due = motor_states_due.pop_front();
          check_field("motor_direction", seen.motor, due.motor);
          check_field("reversing", seen.reversing, due.reversing);
          check_field("lock_active", seen.lock, due.lock);
          check_field("at_top", seen.top, due.top);
          check_field("at_bottom", seen.bottom, due.bottom);
          check_field("motion_owner", seen.owner, due.owner);
        end
        compared_o++;
      end
      pending_o = motor_states_due.size();
    end
  end

endmodule

/* dv/tb_power_window_controller.sv */
// tb_power_window_controller: drives switch ticks and register writes into
// power_window_controller with random gaps and stalls; window_motor_checker judges.
// Depends on pwc_pkg, power_window_controller and window_motor_checker.
`timescale 1ns / 100ps

module tb_power_window_controller;
  import pwc_pkg::*;

  localparam int COUNTER_BITS    = 16;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  // column order: obstacle bottom top lock pass_down pass_up drv_down drv_up
  localparam logic [7:0] ALL_RELEASED = 8'b0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic drv_up = 1'b0, drv_down = 1'b0, pas_up = 1'b0, pas_down = 1'b0;
  logic lock_sw = 1'b0, top_sw = 1'b0, bottom_sw = 1'b0, obstacle = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  dir_t motor_direction;
  logic reversing, lock_active, at_top, at_bottom, motion_owner;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  int mismatches, pending, compared;
  int unsigned ticks_sent = 0;
  int unsigned reg_writes = 0;
  logic idle_en = 1'b1;
  logic squeeze_req = 1'b0;
  logic [CfgW-1:0] hold_thr_set = HOLD_THRESHOLD_RST;
  logic [7:0] sw_level = '0;
  int unsigned dwell_left [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  power_window_controller #(.COUNTER_BITS(COUNTER_BITS)) dut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .driver_up_button_i      (drv_up),
    .driver_down_button_i    (drv_down),
    .passenger_up_button_i   (pas_up),
    .passenger_down_button_i (pas_down),
    .lock_button_i           (lock_sw),
    .top_limit_switch_i      (top_sw),
    .bottom_limit_switch_i   (bottom_sw),
    .obstacle_sensor_i       (obstacle),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .motor_direction_o       (motor_direction),
    .reversing_o             (reversing),
    .lock_active_o           (lock_active),
    .at_top_o                (at_top),
    .at_bottom_o             (at_bottom),
    .motion_owner_o          (motion_owner),
    .cfg_valid_i             (cfg_valid),
    .cfg_ready_o             (cfg_ready),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data)
  );

  window_motor_checker #(.COUNTER_BITS(COUNTER_BITS)) motor_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .levels_i          ({obstacle, bottom_sw, top_sw, lock_sw,
                         pas_down, pas_up, drv_down, drv_up}),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .motor_direction_i (motor_direction),
    .reversing_i       (reversing),
    .lock_active_i     (lock_active),
    .at_top_i          (at_top),
    .at_bottom_i       (at_bottom),
    .motion_owner_i    (motion_owner),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .compared_o        (compared)
  );

  function automatic int unsigned pause_len();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  // column order: obstacle bottom top lock pass_down pass_up drv_down drv_up
  function automatic logic [7:0] directed_tick(input int n);
    case (n)
      1:  return 8'b0000_0001;  // driver up, short press
      2:  return 8'b0000_0000;
      3:  return 8'b0010_0000;  // top limit while moving up
      4:  return 8'b0000_0001;  // up press blocked at top
      5:  return 8'b0000_0010;  // down press clears top
      6:  return 8'b0000_0010;
      7:  return 8'b0000_0010;
      8:  return 8'b0000_0010;
      9:  return 8'b0000_0000;  // long press released: manual stop
      10: return 8'b0001_0000;  // lock on
      11: return 8'b0000_0100;  // passenger locked out
      12: return 8'b0001_1000;  // unlock and passenger down together
      13: return 8'b0000_1001;  // driver takes over
      14: return 8'b0000_0001;  // passenger release, not owner
      15: return 8'b1000_0001;  // obstacle while moving up
      16: return 8'b0000_0110;  // presses ignored during reversal
      17: return 8'b0000_0000;
      18: return 8'b0000_0000;
      19: return 8'b0000_1111;  // all buttons at once
      20: return 8'b1100_0000;  // obstacle with bottom level
      21: return 8'b0100_0000;  // bottom ends reversal
      22: return 8'b0000_0010;  // down press blocked at bottom
      23: return 8'b1111_1111;
      default: return ALL_RELEASED;
    endcase
  endfunction

  // how long a switch stays at a level in well-formed sequences
  function automatic int unsigned dwell(input int b, input logic level);
    int unsigned t;
    if (b < LVL_LOCK) begin
      if (!level) return $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: begin
          t = (hold_thr_set <= 400) ? hold_thr_set + $urandom_range(0, 1)
                                    : $urandom_range(30, 60);
          return (t == 0) ? 1 : t;
        end
        1: return $urandom_range(1, 3);
        default: return $urandom_range(1, 25);
      endcase
    end
    case (b)
      LVL_LOCK:   return level ? $urandom_range(1, 4) : $urandom_range(30, 250);
      LVL_TOP,
      LVL_BOTTOM: return level ? $urandom_range(1, 4) : $urandom_range(10, 80);
      default:    return level ? $urandom_range(1, 3) : $urandom_range(8, 60);
    endcase
  endfunction

  task automatic send_tick(input logic [7:0] vec);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {obstacle, bottom_sw, top_sw, lock_sw, pas_down, pas_up, drv_down, drv_up} <= vec;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [CfgW-1:0] thr, input logic [CfgW-1:0] rev,
                               input logic touch_spare);
    wait_idle();
    cfg_write(REG_HOLD_THRESHOLD, thr);
    cfg_write(REG_REVERSE_TICKS, rev);
    if (touch_spare) cfg_write(REG_SPARE, '1);
    cfg_valid <= 1'b0;
    hold_thr_set = thr;
    @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n_ticks);
    logic [7:0] vec;
    for (int unsigned k = 0; k < n_ticks; k++) begin
      if (k % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      for (int b = 0; b < 8; b++) begin
        if (dwell_left[b] == 0) begin
          sw_level[b]   = ~sw_level[b];
          dwell_left[b] = dwell(b, sw_level[b]);
        end
        dwell_left[b]--;
      end
      vec = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : sw_level;
      send_tick(vec);
    end
    idle_en = 1'b1;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pause_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int b = 0; b < 8; b++) dwell_left[b] = dwell(b, 1'b0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setting(16'd2, 16'd3, 1'b0);
    for (int n = 0; n < 25; n++) send_tick(directed_tick(n));
    squeeze_req = 1'b1;
    run_random(300);

    apply_setting(HOLD_THRESHOLD_RST, REVERSE_TICKS_RST, 1'b0);
    run_random(300);
    apply_setting(16'd0, 16'd1, 1'b0);
    run_random(250);
    apply_setting(16'd0, 16'd0, 1'b1);
    run_random(250);
    apply_setting(16'hFFFF, 16'hFFFF, 1'b0);
    run_random(250);
    apply_setting(16'd7, 16'd30, 1'b0);
    run_random(300);

    wait_idle();
    $display("Sent %0d ticks and %0d register writes; %0d results compared.",
             ticks_sent, reg_writes, compared);
    $display("Covered auto and manual moves, lock, limits, reversal and a long output hold-off.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
